@@ design/atc_pkg.sv @@
// shared types, constants and per-character helper functions for the atom classifier
package atc_pkg;

  localparam int unsigned CODE_W      = 21;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned MAX_ATOM    = 64;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned LIT_W       = 4;
  localparam int unsigned NF_W        = 5;

  localparam longint unsigned CNT_MAX_L = (64'd1 << COUNT_WIDTH) - 64'd1;
  localparam longint unsigned LIMIT_L   =
    (64'(MAX_ATOM) < CNT_MAX_L) ? 64'(MAX_ATOM) : CNT_MAX_L;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX    = COUNT_WIDTH'(CNT_MAX_L);
  localparam logic [COUNT_WIDTH-1:0] ATOM_LIMIT = COUNT_WIDTH'(LIMIT_L);
  localparam longint unsigned LEN_MAX_L = (64'd1 << LEN_W) - 64'd1;

  // number recognizer flag positions
  localparam int unsigned NF_DEAD  = 0;
  localparam int unsigned NF_DIGIT = 1;
  localparam int unsigned NF_DOT   = 2;
  localparam int unsigned NF_EXP   = 3;
  localparam int unsigned NF_ESIGN = 4;
  localparam logic [NF_W-1:0] NF_DEAD_ONLY = NF_W'(1) << NF_DEAD;

  // literal prefix tracker states
  localparam logic [LIT_W-1:0] LIT_NONE       = 4'd0;
  localparam logic [LIT_W-1:0] LIT_NIL_START  = 4'd1;
  localparam logic [LIT_W-1:0] LIT_NIL_DONE   = 4'd3;
  localparam logic [LIT_W-1:0] LIT_TRUE_START = 4'd4;
  localparam logic [LIT_W-1:0] LIT_TRUE_DONE  = 4'd7;
  localparam logic [LIT_W-1:0] LIT_FALSE_START = 4'd8;
  localparam logic [LIT_W-1:0] LIT_FALSE_DONE = 4'd12;

  typedef enum logic [2:0] {
    CLS_NUMBER  = 3'd0,
    CLS_KEYWORD = 3'd1,
    CLS_NIL     = 3'd2,
    CLS_BOOLEAN = 3'd3,
    CLS_SYMBOL  = 3'd4
  } token_class_t;

  typedef struct packed {
    logic                   in_atom;
    logic [COUNT_WIDTH-1:0] count;
    logic                   first_colon;
    logic [LIT_W-1:0]       lit;
    logic [NF_W-1:0]        nf;
  } atc_state_t;

  localparam atc_state_t STATE_CLEAR = '0;

  typedef struct packed {
    logic         emit;
    token_class_t cls;
    logic [LEN_W-1:0] len;
  } atc_result_t;

  // byte expected after each partial literal match, zero when none
  function automatic logic [BYTE_W-1:0] lit_expect(input logic [LIT_W-1:0] s);
    logic [BYTE_W-1:0] e;
    case (s)
      4'd1:    e = "i";
      4'd2:    e = "l";
      4'd4:    e = "r";
      4'd5:    e = "u";
      4'd6:    e = "e";
      4'd8:    e = "a";
      4'd9:    e = "l";
      4'd10:   e = "s";
      4'd11:   e = "e";
      default: e = '0;
    endcase
    return e;
  endfunction

  function automatic logic [LIT_W-1:0] lit_next(input logic [LIT_W-1:0] s,
                                                input logic [BYTE_W-1:0] b,
                                                input logic first);
    logic [LIT_W-1:0]  r;
    logic [BYTE_W-1:0] e;
    e = lit_expect(s);
    r = LIT_NONE;
    if (first) begin
      if (b == "n") r = LIT_NIL_START;
      else if (b == "t") r = LIT_TRUE_START;
      else if (b == "f") r = LIT_FALSE_START;
    end else if (e != '0 && e == b) begin
      r = s + LIT_W'(1);
    end
    return r;
  endfunction

  function automatic logic [NF_W-1:0] num_next(input logic [NF_W-1:0] f_in,
                                               input logic [BYTE_W-1:0] b,
                                               input logic first);
    logic [NF_W-1:0] f;
    logic            sign;
    f    = f_in;
    sign = (b == "+") || (b == "-");
    if (f[NF_DEAD]) begin
      return f;
    end
    if (first && sign) begin
      return f;
    end
    if (f[NF_ESIGN] && sign) begin
      f[NF_ESIGN] = 1'b0;
      return f;
    end
    f[NF_ESIGN] = 1'b0;
    if (b inside {["0":"9"]}) begin
      f[NF_DIGIT] = 1'b1;
      return f;
    end
    if (b == ".") begin
      if (f[NF_EXP] || f[NF_DOT]) return NF_DEAD_ONLY;
      f[NF_DOT] = 1'b1;
      return f;
    end
    if (b == "e" || b == "E") begin
      if (f[NF_EXP] || !f[NF_DIGIT]) return NF_DEAD_ONLY;
      f[NF_EXP]   = 1'b1;
      f[NF_ESIGN] = 1'b1;
      return f;
    end
    return NF_DEAD_ONLY;
  endfunction

endpackage

@@ design/atom_token_classifier.sv @@
// top level of the atom classifier: scan state, result register and handshakes
//
// usage
//   input channel: one character code per word on in_char_code (in_valid/in_ready);
//   code 0 marks end of input and closes any open atom like a delimiter
//   result channel: one word per finished atom on out_token_class and
//   out_atom_length (out_valid/out_ready); delimiters between atoms give nothing
//   result: the result of the delimiter that closes an atom is registered and
//   presented in the cycle after that delimiter is accepted
//   throughput: one character per cycle unless stalled; shallow logic updates
//   the scan state in the accepting cycle and the result register is the only stage
//   stall: in_ready stays high while the result register is empty or being
//   drained this cycle; a held result blocks only new characters, the scan
//   state is kept intact meanwhile
//   reset: rst_n is synchronous, active low; it drops any pending result and
//   leaves the scanner between atoms with all match trackers cleared
module atom_token_classifier (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [atc_pkg::CODE_W-1:0]    in_char_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_token_class,
  output logic [atc_pkg::LEN_W-1:0]     out_atom_length
);

  // scan state and result register
  atc_pkg::atc_state_t          state_r;
  atc_pkg::atc_state_t          state_nxt;
  atc_pkg::atc_result_t         res;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  atc_pkg::token_class_t        cls_r;
  logic [atc_pkg::LEN_W-1:0]    len_r;
  logic                         in_fire;

  // result register frees up as soon as the receiver takes the held word
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  atc_scan u_scan (
    .code (in_char_code),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire && res.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= atc_pkg::STATE_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  // result payload, loaded only when an atom closes
  always_ff @(posedge clk) begin
    if (in_fire && res.emit) begin
      cls_r <= res.cls;
      len_r <= res.len;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_token_class = cls_r;
  assign out_atom_length = len_r;

`ifndef SYNTHESIS
  // closing an open atom always produces a word next cycle
  a_close_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res.emit) |=> out_valid_r)
    else $error("closed atom produced no result");

  // a held result is not dropped while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("stalled result lost");

  // results only come from non-empty atoms
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (len_r != '0))
    else $error("result for empty atom");

  // between atoms the trackers sit cleared
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.in_atom |-> (state_r == atc_pkg::STATE_CLEAR))
    else $error("scan state not cleared between atoms");

  // an over-long atom can only end as a symbol
  a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.count > atc_pkg::ATOM_LIMIT) |->
      (state_r.lit == atc_pkg::LIT_NONE && !state_r.first_colon &&
       state_r.nf == atc_pkg::NF_DEAD_ONLY))
    else $error("over-long atom still matchable");
`endif

endmodule

@@ design/atc_scan.sv @@
// per-character next-state and finished-atom classification logic
module atc_scan (
  input  logic [atc_pkg::CODE_W-1:0] code,
  input  atc_pkg::atc_state_t        cur,
  output atc_pkg::atc_state_t        nxt,
  output atc_pkg::atc_result_t       res
);

  logic                       delim;
  logic                       first;
  logic [atc_pkg::BYTE_W-1:0] b;
  logic [63:0]                cnt64;
  atc_pkg::atc_state_t        base;

  assign b     = code[atc_pkg::BYTE_W-1:0];
  assign first = !cur.in_atom || (cur.count == '0);
  assign cnt64 = 64'(cur.count);

  always_comb begin
    delim = code inside {21'd0, 21'd32, 21'd9, 21'd10, 21'd13, 21'd12, 21'd11,
                         21'd40, 21'd41, 21'd91, 21'd93, 21'd123, 21'd125,
                         21'd34, 21'd59, 21'd39, 21'd96, 21'd126, 21'd44};
  end

  always_comb begin
    base = cur.in_atom ? cur : atc_pkg::STATE_CLEAR;
    nxt  = atc_pkg::STATE_CLEAR;
    res.emit = 1'b0;
    res.len  = (cnt64 > atc_pkg::LEN_MAX_L) ? '1 : cnt64[atc_pkg::LEN_W-1:0];
    if (cur.lit == atc_pkg::LIT_NIL_DONE) begin
      res.cls = atc_pkg::CLS_NIL;
    end else if (cur.lit == atc_pkg::LIT_TRUE_DONE || cur.lit == atc_pkg::LIT_FALSE_DONE) begin
      res.cls = atc_pkg::CLS_BOOLEAN;
    end else if (!cur.nf[atc_pkg::NF_DEAD] && cur.nf[atc_pkg::NF_DIGIT]) begin
      res.cls = atc_pkg::CLS_NUMBER;
    end else if (cur.first_colon && cur.count > atc_pkg::COUNT_WIDTH'(1)) begin
      res.cls = atc_pkg::CLS_KEYWORD;
    end else begin
      res.cls = atc_pkg::CLS_SYMBOL;
    end

    if (delim) begin
      res.emit = cur.in_atom;
    end else begin
      nxt.in_atom     = 1'b1;
      nxt.first_colon = first ? (b == ":") : base.first_colon;
      nxt.lit         = atc_pkg::lit_next(base.lit, b, first);
      nxt.nf          = atc_pkg::num_next(base.nf, b, first);
      // atom is past the length limit: only symbol remains possible
      if (base.count >= atc_pkg::ATOM_LIMIT) begin
        nxt.nf          = atc_pkg::NF_DEAD_ONLY;
        nxt.first_colon = 1'b0;
        nxt.lit         = atc_pkg::LIT_NONE;
      end
      nxt.count = (base.count < atc_pkg::CNT_MAX) ? base.count + atc_pkg::COUNT_WIDTH'(1)
                                                  : base.count;
    end
  end

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for atom_token_classifier: table of words, random atoms, scoreboard
module tb_top;
  import atc_pkg::*;

  // run limits
  localparam int unsigned RANDOM_WORDS = 800;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned NUM_SEPS     = 19;

  typedef struct {
    token_class_t     cls;
    logic [LEN_W-1:0] len;
  } token_word_t;

  // one directed word; typed rows carry the result that the closing delimiter must give
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              typed;
    token_class_t      cls;
    logic [LEN_W-1:0]  len;
  } table_row_t;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic [CODE_W-1:0]    in_char_code = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [2:0]           out_token_class;
  logic [LEN_W-1:0]     out_atom_length;

  always #2 clk = ~clk;

  atom_token_classifier uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_class (out_token_class),
    .out_atom_length (out_atom_length)
  );

  // every code that ends an atom, compared on the full 21 bits
  logic [CODE_W-1:0] sep_codes [NUM_SEPS] = '{
    21'h00, 21'h20, 21'h09, 21'h0A, 21'h0D, 21'h0C, 21'h0B,
    21'h28, 21'h29, 21'h5B, 21'h5D, 21'h7B, 21'h7D,
    21'h22, 21'h3B, 21'h27, 21'h60, 21'h7E, 21'h2C
  };

  // directed words: literals, keyword, lone colon, signed number with exponent,
  // both code extremes and a wide code whose low byte is a space
  table_row_t dir_rows [25] = '{
    '{21'h000000,   1'b0, CLS_SYMBOL,  16'd0},
    '{CODE_W'("n"), 1'b0, CLS_SYMBOL,  16'd0},
    '{CODE_W'("i"), 1'b0, CLS_SYMBOL,  16'd0},
    '{CODE_W'("l"), 1'b0, CLS_SYMBOL,  16'd0},
    '{CODE_W'(" "), 1'b1, CLS_NIL,     16'd3},
    '{CODE_W'("f"), 1'b0, CLS_SYMBOL,  16'd0},
    '{CODE_W'("a"), 1'b0, CLS_SYMBOL,  16'd0},
    '{CODE_W'("l"), 1'b0, CLS_SYMBOL,  16'd0},
    '{CODE_W'("s"), 1'b0, CLS_SYMBOL,  16'd0},
    '{CODE_W'("e"), 1'b0, CLS_SYMBOL,  16'd0},
    '{CODE_W'(","), 1'b1, CLS_BOOLEAN, 16'd5},
    '{CODE_W'(":"), 1'b0, CLS_SYMBOL,  16'd0},
    '{CODE_W'("k"), 1'b0, CLS_SYMBOL,  16'd0},
    '{CODE_W'(";"), 1'b1, CLS_KEYWORD, 16'd2},
    '{CODE_W'(":"), 1'b0, CLS_SYMBOL,  16'd0},
    '{CODE_W'(")"), 1'b1, CLS_SYMBOL,  16'd1},
    '{CODE_W'("-"), 1'b0, CLS_SYMBOL,  16'd0},
    '{CODE_W'("1"), 1'b0, CLS_SYMBOL,  16'd0},
    '{CODE_W'("e"), 1'b0, CLS_SYMBOL,  16'd0},
    '{CODE_W'("+"), 1'b0, CLS_SYMBOL,  16'd0},
    '{CODE_W'("5"), 1'b0, CLS_SYMBOL,  16'd0},
    '{CODE_W'("]"), 1'b0, CLS_SYMBOL,  16'd0},
    '{21'h1FFFFF,   1'b0, CLS_SYMBOL,  16'd0},
    '{21'h100020,   1'b0, CLS_SYMBOL,  16'd0},
    '{21'h000000,   1'b0, CLS_SYMBOL,  16'd0}
  };

  // scoreboard of tokens still owed by the block, oldest first
  token_word_t expected_tokens [$];
  int unsigned err_cnt      = 0;
  int unsigned sent_cnt     = 0;
  int unsigned burst_left   = 0;
  int unsigned stall_cycles = 0;

  // shadow scan state
  logic                   scan_open  = 1'b0;
  logic [COUNT_WIDTH-1:0] scan_len   = '0;
  logic                   colon_lead = 1'b0;
  logic [LIT_W-1:0]       lit_state  = LIT_NONE;
  logic [NF_W-1:0]        num_flags  = '0;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic logic is_separator(input logic [CODE_W-1:0] code);
    for (int i = 0; i < NUM_SEPS; i++) begin
      if (code == sep_codes[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // printable byte that keeps an atom open
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(33, 126)); while (is_separator(CODE_W'(b)));
    return b;
  endfunction

  // progress through "nil", "true" or "false"
  function automatic logic [LIT_W-1:0] lit_advance(input logic [LIT_W-1:0] s,
                                                   input logic [7:0] b,
                                                   input logic first);
    logic [7:0] want;
    if (first) begin
      case (b)
        "n":     return LIT_NIL_START;
        "t":     return LIT_TRUE_START;
        "f":     return LIT_FALSE_START;
        default: return LIT_NONE;
      endcase
    end
    case (s)
      LIT_NIL_START:           want = "i";
      LIT_NIL_START + 4'd1:    want = "l";
      LIT_TRUE_START:          want = "r";
      LIT_TRUE_START + 4'd1:   want = "u";
      LIT_TRUE_START + 4'd2:   want = "e";
      LIT_FALSE_START:         want = "a";
      LIT_FALSE_START + 4'd1:  want = "l";
      LIT_FALSE_START + 4'd2:  want = "s";
      LIT_FALSE_START + 4'd3:  want = "e";
      default:                 want = 8'd0;
    endcase
    return (want != 8'd0 && want == b) ? s + LIT_W'(1) : LIT_NONE;
  endfunction

  // number recognizer, one byte at a time
  function automatic logic [NF_W-1:0] num_advance(input logic [NF_W-1:0] f,
                                                  input logic [7:0] b,
                                                  input logic first);
    logic [NF_W-1:0] g;
    logic            is_sign;
    g       = f;
    is_sign = (b == "+") || (b == "-");
    if (g[NF_DEAD] || (first && is_sign)) return g;
    if (g[NF_ESIGN] && is_sign) begin
      g[NF_ESIGN] = 1'b0;
      return g;
    end
    g[NF_ESIGN] = 1'b0;
    if (b >= "0" && b <= "9") begin
      g[NF_DIGIT] = 1'b1;
    end else if (b == ".") begin
      if (g[NF_EXP] || g[NF_DOT]) g = NF_DEAD_ONLY;
      else g[NF_DOT] = 1'b1;
    end else if (b == "e" || b == "E") begin
      if (g[NF_EXP] || !g[NF_DIGIT]) begin
        g = NF_DEAD_ONLY;
      end else begin
        g[NF_EXP]   = 1'b1;
        g[NF_ESIGN] = 1'b1;
      end
    end else begin
      g = NF_DEAD_ONLY;
    end
    return g;
  endfunction

  // advance the shadow scanner by one accepted code; emit marks a finished atom
  task automatic scan_char(input logic [CODE_W-1:0] code, output logic emit,
                           output token_class_t cls, output logic [LEN_W-1:0] len);
    logic [7:0]      lo;
    logic            first;
    longint unsigned n;
    emit = 1'b0;
    cls  = CLS_SYMBOL;
    len  = '0;
    lo   = code[7:0];
    if (is_separator(code)) begin
      if (scan_open) begin
        emit = 1'b1;
        // precedence: nil, boolean, number, keyword, symbol
        if (lit_state == LIT_NIL_DONE) cls = CLS_NIL;
        else if (lit_state == LIT_TRUE_DONE || lit_state == LIT_FALSE_DONE) cls = CLS_BOOLEAN;
        else if (!num_flags[NF_DEAD] && num_flags[NF_DIGIT]) cls = CLS_NUMBER;
        else if (colon_lead && scan_len > 1) cls = CLS_KEYWORD;
        n   = longint'(scan_len);
        len = (n > LEN_MAX_L) ? LEN_W'(LEN_MAX_L) : LEN_W'(n);
        scan_open  = 1'b0;
        scan_len   = '0;
        colon_lead = 1'b0;
        lit_state  = LIT_NONE;
        num_flags  = '0;
      end
    end else begin
      first     = !scan_open || scan_len == 0;
      scan_open = 1'b1;
      if (first) colon_lead = (lo == ":");
      lit_state = lit_advance(lit_state, lo, first);
      num_flags = num_advance(num_flags, lo, first);
      // past the length limit only a symbol is possible
      if (scan_len >= ATOM_LIMIT) begin
        num_flags  = NF_DEAD_ONLY;
        colon_lead = 1'b0;
        lit_state  = LIT_NONE;
      end
      if (scan_len < CNT_MAX) scan_len++;
    end
  endtask

  // send one word in bursts with random gaps, then predict from it once accepted
  task automatic put_char(input logic [CODE_W-1:0] code, input logic typed,
                          input token_class_t t_cls, input logic [LEN_W-1:0] t_len);
    int unsigned  gap;
    logic         emit;
    token_class_t p_cls;
    logic [LEN_W-1:0] p_len;
    token_word_t  tok;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      // lower valid only for a real gap, so it is never dropped and raised in one step
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_char_code <= code;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
    scan_char(code, emit, p_cls, p_len);
    if (emit || typed) begin
      if (typed) begin
        tok.cls = t_cls;
        tok.len = t_len;
      end else begin
        tok.cls = p_cls;
        tok.len = p_len;
      end
      expected_tokens.push_back(tok);
    end
  endtask

  // receiver: free runs, stall stretches and quick toggling
  int unsigned rdy_left = 0;
  logic        rdy_on   = 1'b0;
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          rdy_on   = 1'b1;
          rdy_left = $urandom_range(20, 80);
        end
        1: begin
          rdy_on   = 1'b0;
          rdy_left = $urandom_range(1, 15);
        end
        default: begin
          rdy_on   = ~rdy_on;
          rdy_left = $urandom_range(1, 4);
        end
      endcase
    end else begin
      rdy_left--;
    end
    out_ready <= rdy_on;
  end

  // compare every accepted result word with the oldest expected token
  token_word_t head_tok;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        report($sformatf("unexpected token class %0d length %0d",
                         out_token_class, out_atom_length));
      end else begin
        head_tok = expected_tokens.pop_front();
        if (out_token_class !== head_tok.cls)
          report($sformatf("token class %0d, expected %0d", out_token_class, head_tok.cls));
        if (out_atom_length !== head_tok.len)
          report($sformatf("atom length %0d, expected %0d", out_atom_length, head_tok.len));
      end
    end
  end

  // watchdog: too long without any word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [CODE_W-1:0] atom_q [$];
    string             lit_word;
    logic [7:0]        lead;
    int unsigned       n;
    logic              paused;
    paused = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i])
      put_char(dir_rows[i].code, dir_rows[i].typed, dir_rows[i].cls, dir_rows[i].len);

    // random atoms, mostly well formed, each closed by one or more delimiters
    while (sent_cnt < RANDOM_WORDS) begin
      // halfway: hold the sender until the scoreboard drains
      if (!paused && sent_cnt >= RANDOM_WORDS / 2) begin
        paused     = 1'b1;
        in_valid  <= 1'b0;
        do @(posedge clk); while (expected_tokens.size() != 0);
        burst_left = 0;
      end
      atom_q.delete();
      case ($urandom_range(0, 9))
        0, 1: begin
          // literal, sometimes cut short, extended or altered
          case ($urandom_range(0, 2))
            0:       lit_word = "nil";
            1:       lit_word = "true";
            default: lit_word = "false";
          endcase
          for (int i = 0; i < lit_word.len(); i++) atom_q.push_back(CODE_W'(lit_word[i]));
          case ($urandom_range(0, 5))
            0: void'(atom_q.pop_back());
            1: atom_q.push_back(CODE_W'(plain_byte()));
            2: atom_q[$urandom_range(0, atom_q.size() - 1)] = CODE_W'(plain_byte());
            default: ;
          endcase
        end
        2, 3: begin
          // number: sign, digits, dot, exponent, with the odd stray character
          if ($urandom_range(0, 2) == 0)
            atom_q.push_back(CODE_W'($urandom_range(0, 1) ? "-" : "+"));
          repeat ($urandom_range(0, 4)) atom_q.push_back(CODE_W'("0" + $urandom_range(0, 9)));
          if ($urandom_range(0, 2) == 0) begin
            atom_q.push_back(CODE_W'("."));
            repeat ($urandom_range(0, 3)) atom_q.push_back(CODE_W'("0" + $urandom_range(0, 9)));
          end
          if ($urandom_range(0, 2) == 0) begin
            atom_q.push_back(CODE_W'($urandom_range(0, 1) ? "e" : "E"));
            if ($urandom_range(0, 1))
              atom_q.push_back(CODE_W'($urandom_range(0, 1) ? "-" : "+"));
            repeat ($urandom_range(0, 3)) atom_q.push_back(CODE_W'("0" + $urandom_range(0, 9)));
          end
          if (atom_q.size() == 0) atom_q.push_back(CODE_W'("7"));
          if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 5))
              0:       lead = "+";
              1:       lead = "-";
              2:       lead = ".";
              3:       lead = "e";
              4:       lead = "E";
              default: lead = plain_byte();
            endcase
            atom_q.insert($urandom_range(0, atom_q.size()), CODE_W'(lead));
          end
        end
        4: begin
          // keyword, or a lone colon
          atom_q.push_back(CODE_W'(":"));
          repeat ($urandom_range(0, 6)) atom_q.push_back(CODE_W'(plain_byte()));
        end
        5: repeat ($urandom_range(1, 8)) atom_q.push_back(CODE_W'(plain_byte()));
        6: begin
          // around the length limit, starting like a keyword or a number
          lead = $urandom_range(0, 1) ? ":" : "1";
          atom_q.push_back(CODE_W'(lead));
          n = $urandom_range(int'(ATOM_LIMIT) - 3, int'(ATOM_LIMIT) + 4);
          repeat (n) begin
            if (lead == ":") atom_q.push_back(CODE_W'(plain_byte()));
            else atom_q.push_back(CODE_W'("0" + $urandom_range(0, 9)));
          end
        end
        7: begin
          // wide codes, low bytes often mimicking delimiters or digits
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1)) lead = sep_codes[$urandom_range(0, NUM_SEPS - 1)][7:0];
            else lead = $urandom_range(0, 1) ? 8'("0" + $urandom_range(0, 9)) : plain_byte();
            atom_q.push_back({13'($urandom_range(1, 13'h1FFF)), lead});
          end
        end
        8: repeat ($urandom_range(1, 5)) atom_q.push_back(CODE_W'($urandom & 21'h1FFFFF));
        default: ;
      endcase
      repeat ($urandom_range(1, 3)) atom_q.push_back(sep_codes[$urandom_range(0, NUM_SEPS - 1)]);
      foreach (atom_q[i]) put_char(atom_q[i], 1'b0, CLS_SYMBOL, '0);
    end

    // drain, then let the clock run on before the final report
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/atc_pkg.sv
design/atc_scan.sv
design/atom_token_classifier.sv
dv/tb_top.sv
